// ===== hdl/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// Point to segment projection package
// Widths, region codes and item types shared by the projection pipeline.
// ----------------------------------------------------------------------------
package psp_pkg;

    localparam int COORD_WIDTH = 32;

    localparam int VW      = COORD_WIDTH + 1;
    localparam int PW      = 2 * VW;
    localparam int SW      = PW + 1;
    localparam int MW      = 2 * COORD_WIDTH + 1;
    localparam int OW      = 3 * COORD_WIDTH + 1;
    localparam int OWX     = OW + 1;
    localparam int CW      = 4 * COORD_WIDTH + 2;
    localparam int CWX     = CW + 1;
    localparam int QW      = COORD_WIDTH;
    localparam int DQW     = MW;
    localparam int RW      = COORD_WIDTH + 1;
    localparam int SQW     = 2 * RW + 1;
    localparam int LATENCY = DQW + RW + 7;

    typedef enum logic [1:0] {
        REGION_BEFORE   = 2'd0,
        REGION_PAST     = 2'd1,
        REGION_INTERIOR = 2'd2
    } region_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t query_x;
        coord_t query_y;
    } in_t;

    typedef struct packed {
        coord_t                   near_x;
        coord_t                   near_y;
        logic [COORD_WIDTH-1:0]   distance;
        region_t                  region;
        logic                     degenerate;
        logic                     saturated;
    } out_t;

    typedef struct packed {
        coord_t          sx;
        coord_t          sy;
        coord_t          ex;
        coord_t          ey;
        logic            vxneg;
        logic            vyneg;
        region_t         region;
        logic            degen;
        logic [MW-1:0]   vv;
        logic [MW-1:0]   nsel;
    } ctx_t;

    typedef struct packed {
        coord_t    near_x;
        coord_t    near_y;
        region_t   region;
        logic      degen;
    } tail_t;

endpackage

// ===== hdl/point_segment_projection_unit.sv =====
// ----------------------------------------------------------------------------
// Point to segment projection unit
// Nearest point on a segment and Euclidean distance, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request with a segment (start, end) and a query point, all signed
//   Q16.16, and raise start. A transfer happens at each rising edge where
//   start is high and busy is low; busy never rises, so one item may enter
//   every cycle. Items are independent and leave in order.
//   Each result is on result for exactly one cycle, marked by done, and is
//   taken at the edge that ends that cycle. The receiver cannot stall.
//   Throughput: one item per cycle.
//   The latency is set by the restoring divider for cross^2 / |v|^2, one
//   quotient bit per stage (2W+1 stages), followed by the square root, one
//   result bit per stage (W+1 stages), after five stages of subtraction,
//   33x33 products, sums, split products and partial product merging.
//   Reset clears all valid bits; items in flight are dropped and no result
//   appears until a new item is accepted.
// ----------------------------------------------------------------------------
module point_segment_projection_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  psp_pkg::in_t   request,
    output logic           done,
    output psp_pkg::out_t  result
);

    // stage 1: differences
    logic                          s1_valid_reg;
    psp_pkg::coord_t               s1_sx_reg, s1_sy_reg, s1_ex_reg, s1_ey_reg;
    logic signed [psp_pkg::VW-1:0] s1_vx_reg, s1_vy_reg;
    logic signed [psp_pkg::VW-1:0] s1_spx_reg, s1_spy_reg, s1_epx_reg, s1_epy_reg;
    logic [psp_pkg::VW-1:0]        s1_avx, s1_avy;

    // stage 2: products
    logic                          s2_valid_reg;
    psp_pkg::coord_t               s2_sx_reg, s2_sy_reg, s2_ex_reg, s2_ey_reg;
    logic                          s2_vxneg_reg, s2_vyneg_reg;
    logic [psp_pkg::COORD_WIDTH-1:0] s2_avx_reg, s2_avy_reg;
    logic signed [psp_pkg::PW-1:0] s2_d1x_reg, s2_d1y_reg, s2_d2x_reg, s2_d2y_reg;
    logic signed [psp_pkg::PW-1:0] s2_vvx_reg, s2_vvy_reg, s2_cra_reg, s2_crb_reg;
    logic signed [psp_pkg::PW-1:0] s2_spx2_reg, s2_spy2_reg, s2_epx2_reg, s2_epy2_reg;

    // stage 3: sums
    logic                          s3_valid_reg;
    psp_pkg::coord_t               s3_sx_reg, s3_sy_reg, s3_ex_reg, s3_ey_reg;
    logic                          s3_vxneg_reg, s3_vyneg_reg;
    logic [psp_pkg::COORD_WIDTH-1:0] s3_avx_reg, s3_avy_reg;
    logic signed [psp_pkg::SW-1:0] s3_d1_reg, s3_d2_reg, s3_cr_reg;
    logic [psp_pkg::MW-1:0]        s3_vv_reg, s3_nsp_reg, s3_nep_reg;

    // stage 4: classification and split products
    psp_pkg::region_t              s3_region;
    logic [psp_pkg::MW-1:0]        s3_d1m, s3_crabs;
    logic [psp_pkg::SW-1:0]        s3_crneg;
    logic                          s4_valid_reg;
    psp_pkg::ctx_t                 s4_ctx_reg;
    logic [2*psp_pkg::COORD_WIDTH-1:0] s4_axlo_reg, s4_aylo_reg, s4_ccll_reg;
    logic [2*psp_pkg::COORD_WIDTH:0]   s4_axhi_reg, s4_ayhi_reg, s4_cchl_reg;
    logic [2*psp_pkg::COORD_WIDTH+1:0] s4_cchh_reg;

    // divider stages
    logic                          div_valid_reg [0:psp_pkg::DQW];
    psp_pkg::ctx_t                 div_ctx_reg   [0:psp_pkg::DQW];
    psp_pkg::ctx_t                 div_ctx_next  [0:psp_pkg::DQW];
    logic [psp_pkg::CW-1:0]        cr_rem_reg    [0:psp_pkg::DQW];
    logic [psp_pkg::CW-1:0]        cr_rem_next   [0:psp_pkg::DQW];
    logic [psp_pkg::DQW-1:0]       cr_q_reg      [0:psp_pkg::DQW];
    logic [psp_pkg::DQW-1:0]       cr_q_next     [0:psp_pkg::DQW];
    logic [psp_pkg::OW-1:0]        ox_rem_reg    [0:psp_pkg::DQW];
    logic [psp_pkg::OW-1:0]        ox_rem_next   [0:psp_pkg::DQW];
    logic [psp_pkg::OW-1:0]        oy_rem_reg    [0:psp_pkg::DQW];
    logic [psp_pkg::OW-1:0]        oy_rem_next   [0:psp_pkg::DQW];
    logic [psp_pkg::QW-1:0]        ox_q_reg      [0:psp_pkg::DQW];
    logic [psp_pkg::QW-1:0]        ox_q_next     [0:psp_pkg::DQW];
    logic [psp_pkg::QW-1:0]        oy_q_reg      [0:psp_pkg::DQW];
    logic [psp_pkg::QW-1:0]        oy_q_next     [0:psp_pkg::DQW];

    // square root stages
    logic                          sq_valid_reg  [0:psp_pkg::RW];
    psp_pkg::tail_t                sq_tail_reg   [0:psp_pkg::RW];
    psp_pkg::tail_t                sq_tail_next  [0:psp_pkg::RW];
    logic [psp_pkg::MW-1:0]        sq_rem_reg    [0:psp_pkg::RW];
    logic [psp_pkg::MW-1:0]        sq_rem_next   [0:psp_pkg::RW];
    logic [psp_pkg::RW-1:0]        sq_res_reg    [0:psp_pkg::RW];
    logic [psp_pkg::RW-1:0]        sq_res_next   [0:psp_pkg::RW];

    // output
    logic                          done_reg;
    psp_pkg::out_t                 result_reg;
    psp_pkg::out_t                 result_next;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            for (int k = 0; k <= psp_pkg::DQW; k++)
            begin
                div_valid_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= psp_pkg::RW; j++)
            begin
                sq_valid_reg[j] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= start && !busy;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            div_valid_reg[0] <= s4_valid_reg;
            for (int k = 0; k < psp_pkg::DQW; k++)
            begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
            sq_valid_reg[0] <= div_valid_reg[psp_pkg::DQW];
            for (int j = 0; j < psp_pkg::RW; j++)
            begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
            done_reg <= sq_valid_reg[psp_pkg::RW];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sx_reg  <= request.start_x;
        s1_sy_reg  <= request.start_y;
        s1_ex_reg  <= request.end_x;
        s1_ey_reg  <= request.end_y;
        s1_vx_reg  <= {request.end_x[psp_pkg::COORD_WIDTH-1], request.end_x}
                    - {request.start_x[psp_pkg::COORD_WIDTH-1], request.start_x};
        s1_vy_reg  <= {request.end_y[psp_pkg::COORD_WIDTH-1], request.end_y}
                    - {request.start_y[psp_pkg::COORD_WIDTH-1], request.start_y};
        s1_spx_reg <= {request.query_x[psp_pkg::COORD_WIDTH-1], request.query_x}
                    - {request.start_x[psp_pkg::COORD_WIDTH-1], request.start_x};
        s1_spy_reg <= {request.query_y[psp_pkg::COORD_WIDTH-1], request.query_y}
                    - {request.start_y[psp_pkg::COORD_WIDTH-1], request.start_y};
        s1_epx_reg <= {request.query_x[psp_pkg::COORD_WIDTH-1], request.query_x}
                    - {request.end_x[psp_pkg::COORD_WIDTH-1], request.end_x};
        s1_epy_reg <= {request.query_y[psp_pkg::COORD_WIDTH-1], request.query_y}
                    - {request.end_y[psp_pkg::COORD_WIDTH-1], request.end_y};
    end

    assign s1_avx = s1_vx_reg[psp_pkg::VW-1] ? (~s1_vx_reg + 1'b1) : s1_vx_reg;
    assign s1_avy = s1_vy_reg[psp_pkg::VW-1] ? (~s1_vy_reg + 1'b1) : s1_vy_reg;

    always_ff @(posedge clk)
    begin
        s2_sx_reg    <= s1_sx_reg;
        s2_sy_reg    <= s1_sy_reg;
        s2_ex_reg    <= s1_ex_reg;
        s2_ey_reg    <= s1_ey_reg;
        s2_vxneg_reg <= s1_vx_reg[psp_pkg::VW-1];
        s2_vyneg_reg <= s1_vy_reg[psp_pkg::VW-1];
        s2_avx_reg   <= s1_avx[psp_pkg::COORD_WIDTH-1:0];
        s2_avy_reg   <= s1_avy[psp_pkg::COORD_WIDTH-1:0];
        s2_d1x_reg   <= s1_vx_reg * s1_spx_reg;
        s2_d1y_reg   <= s1_vy_reg * s1_spy_reg;
        s2_d2x_reg   <= s1_vx_reg * s1_epx_reg;
        s2_d2y_reg   <= s1_vy_reg * s1_epy_reg;
        s2_vvx_reg   <= s1_vx_reg * s1_vx_reg;
        s2_vvy_reg   <= s1_vy_reg * s1_vy_reg;
        s2_cra_reg   <= s1_vx_reg * s1_spy_reg;
        s2_crb_reg   <= s1_vy_reg * s1_spx_reg;
        s2_spx2_reg  <= s1_spx_reg * s1_spx_reg;
        s2_spy2_reg  <= s1_spy_reg * s1_spy_reg;
        s2_epx2_reg  <= s1_epx_reg * s1_epx_reg;
        s2_epy2_reg  <= s1_epy_reg * s1_epy_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_sx_reg    <= s2_sx_reg;
        s3_sy_reg    <= s2_sy_reg;
        s3_ex_reg    <= s2_ex_reg;
        s3_ey_reg    <= s2_ey_reg;
        s3_vxneg_reg <= s2_vxneg_reg;
        s3_vyneg_reg <= s2_vyneg_reg;
        s3_avx_reg   <= s2_avx_reg;
        s3_avy_reg   <= s2_avy_reg;
        s3_d1_reg    <= {s2_d1x_reg[psp_pkg::PW-1], s2_d1x_reg}
                      + {s2_d1y_reg[psp_pkg::PW-1], s2_d1y_reg};
        s3_d2_reg    <= {s2_d2x_reg[psp_pkg::PW-1], s2_d2x_reg}
                      + {s2_d2y_reg[psp_pkg::PW-1], s2_d2y_reg};
        s3_cr_reg    <= {s2_cra_reg[psp_pkg::PW-1], s2_cra_reg}
                      - {s2_crb_reg[psp_pkg::PW-1], s2_crb_reg};
        s3_vv_reg    <= {1'b0, s2_vvx_reg[2*psp_pkg::COORD_WIDTH-1:0]}
                      + {1'b0, s2_vvy_reg[2*psp_pkg::COORD_WIDTH-1:0]};
        s3_nsp_reg   <= {1'b0, s2_spx2_reg[2*psp_pkg::COORD_WIDTH-1:0]}
                      + {1'b0, s2_spy2_reg[2*psp_pkg::COORD_WIDTH-1:0]};
        s3_nep_reg   <= {1'b0, s2_epx2_reg[2*psp_pkg::COORD_WIDTH-1:0]}
                      + {1'b0, s2_epy2_reg[2*psp_pkg::COORD_WIDTH-1:0]};
    end

    always_comb
    begin
        if (s3_d1_reg[psp_pkg::SW-1])
        begin
            s3_region = psp_pkg::REGION_BEFORE;
        end
        else if (!s3_d2_reg[psp_pkg::SW-1] && (s3_d2_reg != '0))
        begin
            s3_region = psp_pkg::REGION_PAST;
        end
        else
        begin
            s3_region = psp_pkg::REGION_INTERIOR;
        end
        s3_d1m   = s3_d1_reg[psp_pkg::MW-1:0];
        s3_crneg = ~s3_cr_reg + 1'b1;
        s3_crabs = s3_cr_reg[psp_pkg::SW-1] ? s3_crneg[psp_pkg::MW-1:0]
                                            : s3_cr_reg[psp_pkg::MW-1:0];
    end

    always_ff @(posedge clk)
    begin
        s4_ctx_reg.sx     <= s3_sx_reg;
        s4_ctx_reg.sy     <= s3_sy_reg;
        s4_ctx_reg.ex     <= s3_ex_reg;
        s4_ctx_reg.ey     <= s3_ey_reg;
        s4_ctx_reg.vxneg  <= s3_vxneg_reg;
        s4_ctx_reg.vyneg  <= s3_vyneg_reg;
        s4_ctx_reg.region <= s3_region;
        s4_ctx_reg.degen  <= (s3_vv_reg == '0);
        s4_ctx_reg.vv     <= s3_vv_reg;
        s4_ctx_reg.nsel   <= (s3_region == psp_pkg::REGION_PAST) ? s3_nep_reg : s3_nsp_reg;
        s4_axlo_reg <= s3_avx_reg * s3_d1m[psp_pkg::COORD_WIDTH-1:0];
        s4_axhi_reg <= s3_avx_reg * s3_d1m[psp_pkg::MW-1:psp_pkg::COORD_WIDTH];
        s4_aylo_reg <= s3_avy_reg * s3_d1m[psp_pkg::COORD_WIDTH-1:0];
        s4_ayhi_reg <= s3_avy_reg * s3_d1m[psp_pkg::MW-1:psp_pkg::COORD_WIDTH];
        s4_cchh_reg <= s3_crabs[psp_pkg::MW-1:psp_pkg::COORD_WIDTH]
                     * s3_crabs[psp_pkg::MW-1:psp_pkg::COORD_WIDTH];
        s4_cchl_reg <= s3_crabs[psp_pkg::MW-1:psp_pkg::COORD_WIDTH]
                     * s3_crabs[psp_pkg::COORD_WIDTH-1:0];
        s4_ccll_reg <= s3_crabs[psp_pkg::COORD_WIDTH-1:0]
                     * s3_crabs[psp_pkg::COORD_WIDTH-1:0];
    end

    always_comb
    begin
        logic [psp_pkg::CWX-1:0] cr_trial;
        logic [psp_pkg::OWX-1:0] ox_trial;
        logic [psp_pkg::OWX-1:0] oy_trial;

        div_ctx_next[0] = s4_ctx_reg;
        cr_rem_next[0]  = psp_pkg::CW'(s4_ccll_reg)
                        + (psp_pkg::CW'(s4_cchl_reg) << (psp_pkg::COORD_WIDTH + 1))
                        + (psp_pkg::CW'(s4_cchh_reg) << (2 * psp_pkg::COORD_WIDTH));
        cr_q_next[0]    = '0;
        ox_rem_next[0]  = psp_pkg::OW'(s4_axlo_reg)
                        + (psp_pkg::OW'(s4_axhi_reg) << psp_pkg::COORD_WIDTH);
        oy_rem_next[0]  = psp_pkg::OW'(s4_aylo_reg)
                        + (psp_pkg::OW'(s4_ayhi_reg) << psp_pkg::COORD_WIDTH);
        ox_q_next[0]    = '0;
        oy_q_next[0]    = '0;

        for (int k = 0; k < psp_pkg::DQW; k++)
        begin
            div_ctx_next[k+1] = div_ctx_reg[k];
            cr_rem_next[k+1]  = cr_rem_reg[k];
            cr_q_next[k+1]    = cr_q_reg[k];
            ox_rem_next[k+1]  = ox_rem_reg[k];
            ox_q_next[k+1]    = ox_q_reg[k];
            oy_rem_next[k+1]  = oy_rem_reg[k];
            oy_q_next[k+1]    = oy_q_reg[k];

            cr_trial = psp_pkg::CWX'(div_ctx_reg[k].vv) << (psp_pkg::DQW - 1 - k);
            if ({1'b0, cr_rem_reg[k]} >= cr_trial)
            begin
                cr_rem_next[k+1] = cr_rem_reg[k] - cr_trial[psp_pkg::CW-1:0];
                cr_q_next[k+1][psp_pkg::DQW-1-k] = 1'b1;
            end
        end

        for (int k = 0; k < psp_pkg::QW; k++)
        begin
            ox_trial = psp_pkg::OWX'(div_ctx_reg[k].vv) << (psp_pkg::QW - 1 - k);
            oy_trial = ox_trial;
            if ({1'b0, ox_rem_reg[k]} >= ox_trial)
            begin
                ox_rem_next[k+1] = ox_rem_reg[k] - ox_trial[psp_pkg::OW-1:0];
                ox_q_next[k+1][psp_pkg::QW-1-k] = 1'b1;
            end
            if ({1'b0, oy_rem_reg[k]} >= oy_trial)
            begin
                oy_rem_next[k+1] = oy_rem_reg[k] - oy_trial[psp_pkg::OW-1:0];
                oy_q_next[k+1][psp_pkg::QW-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= psp_pkg::DQW; k++)
        begin
            div_ctx_reg[k] <= div_ctx_next[k];
            cr_rem_reg[k]  <= cr_rem_next[k];
            cr_q_reg[k]    <= cr_q_next[k];
            ox_rem_reg[k]  <= ox_rem_next[k];
            ox_q_reg[k]    <= ox_q_next[k];
            oy_rem_reg[k]  <= oy_rem_next[k];
            oy_q_reg[k]    <= oy_q_next[k];
        end
    end

    always_comb
    begin
        psp_pkg::ctx_t                 c;
        logic                          full;
        logic [psp_pkg::VW-1:0]        offx, offy, nxw, nyw;
        logic [psp_pkg::SQW-1:0]       sq_trial;

        c    = div_ctx_reg[psp_pkg::DQW];
        full = (c.region == psp_pkg::REGION_INTERIOR) && !c.degen;
        offx = {1'b0, ox_q_reg[psp_pkg::DQW]};
        offy = {1'b0, oy_q_reg[psp_pkg::DQW]};
        nxw  = {c.sx[psp_pkg::COORD_WIDTH-1], c.sx} + (c.vxneg ? (~offx + 1'b1) : offx);
        nyw  = {c.sy[psp_pkg::COORD_WIDTH-1], c.sy} + (c.vyneg ? (~offy + 1'b1) : offy);

        sq_rem_next[0]         = full ? cr_q_reg[psp_pkg::DQW] : c.nsel;
        sq_res_next[0]         = '0;
        sq_tail_next[0].region = c.region;
        sq_tail_next[0].degen  = c.degen;
        if (full)
        begin
            sq_tail_next[0].near_x = nxw[psp_pkg::COORD_WIDTH-1:0];
            sq_tail_next[0].near_y = nyw[psp_pkg::COORD_WIDTH-1:0];
        end
        else if (c.region == psp_pkg::REGION_PAST)
        begin
            sq_tail_next[0].near_x = c.ex;
            sq_tail_next[0].near_y = c.ey;
        end
        else
        begin
            sq_tail_next[0].near_x = c.sx;
            sq_tail_next[0].near_y = c.sy;
        end

        for (int j = 0; j < psp_pkg::RW; j++)
        begin
            sq_tail_next[j+1] = sq_tail_reg[j];
            sq_rem_next[j+1]  = sq_rem_reg[j];
            sq_res_next[j+1]  = sq_res_reg[j];
            sq_trial = (psp_pkg::SQW'(sq_res_reg[j]) << (psp_pkg::RW - j))
                     + (psp_pkg::SQW'(1) << (2 * (psp_pkg::RW - 1 - j)));
            if (psp_pkg::SQW'(sq_rem_reg[j]) >= sq_trial)
            begin
                sq_rem_next[j+1] = sq_rem_reg[j] - sq_trial[psp_pkg::MW-1:0];
                sq_res_next[j+1][psp_pkg::RW-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= psp_pkg::RW; j++)
        begin
            sq_tail_reg[j] <= sq_tail_next[j];
            sq_rem_reg[j]  <= sq_rem_next[j];
            sq_res_reg[j]  <= sq_res_next[j];
        end
    end

    always_comb
    begin
        logic [psp_pkg::RW-1:0] root;

        root                   = sq_res_reg[psp_pkg::RW];
        result_next.near_x     = sq_tail_reg[psp_pkg::RW].near_x;
        result_next.near_y     = sq_tail_reg[psp_pkg::RW].near_y;
        result_next.region     = sq_tail_reg[psp_pkg::RW].region;
        result_next.degenerate = sq_tail_reg[psp_pkg::RW].degen;
        result_next.saturated  = root[psp_pkg::RW-1];
        result_next.distance   = root[psp_pkg::RW-1] ? '1 : root[psp_pkg::COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(psp_pkg::LATENCY) done)
        else $error("accepted item did not produce a result on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(psp_pkg::LATENCY) !done)
        else $error("result strobe without an accepted item");

    a_degen_region: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |-> (result.region == psp_pkg::REGION_INTERIOR))
        else $error("degenerate segment outside interior region");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated) |-> (&result.distance))
        else $error("saturated distance not clamped");

endmodule

// ===== bench/point_segment_projection_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Point to segment projection unit testbench
// Streams segment/query items through the unit with random start gaps and
// checks every result, in order, against an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module point_segment_projection_unit_tb;

    typedef logic signed [255:0] wide_t;

    localparam int NUM_RANDOM  = 1230;
    localparam int STALL_LIMIT = 4000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    psp_pkg::in_t   request;
    logic           done;
    psp_pkg::out_t  result;

    psp_pkg::in_t   pending_items[$];
    psp_pkg::out_t  expected_results[$];
    int    sent_count;
    int    checked_count;
    int    error_count;
    int    quiet_cycles;
    int    n_before;
    int    n_past;
    int    n_interior;
    int    n_degen;
    int    n_sat;

    point_segment_projection_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic wide_t floor_sqrt(wide_t n);
        logic [255:0] root;
        logic [255:0] trial;
        root = '0;
        for (int i = 80; i >= 0; i--)
        begin
            trial = root | (256'd1 << i);
            if (trial * trial <= n)
                root = trial;
        end
        return wide_t'(root);
    endfunction

    function automatic psp_pkg::out_t project_point(psp_pkg::in_t item);
        wide_t sx, sy, ex, ey, px, py;
        wide_t vx, vy, spx, spy, epx, epy;
        wide_t d1, d2, vv, cr, span_len;
        psp_pkg::out_t  r;
        sx  = wide_t'(item.start_x);
        sy  = wide_t'(item.start_y);
        ex  = wide_t'(item.end_x);
        ey  = wide_t'(item.end_y);
        px  = wide_t'(item.query_x);
        py  = wide_t'(item.query_y);
        vx  = ex - sx;
        vy  = ey - sy;
        spx = px - sx;
        spy = py - sy;
        epx = px - ex;
        epy = py - ey;
        d1  = vx * spx + vy * spy;
        d2  = vx * epx + vy * epy;
        vv  = vx * vx + vy * vy;
        r.degenerate = 1'b0;
        if (d1 < 0)
        begin
            r.region = psp_pkg::REGION_BEFORE;
            r.near_x = item.start_x;
            r.near_y = item.start_y;
            span_len = floor_sqrt(spx * spx + spy * spy);
        end
        else if (d2 > 0)
        begin
            r.region = psp_pkg::REGION_PAST;
            r.near_x = item.end_x;
            r.near_y = item.end_y;
            span_len = floor_sqrt(epx * epx + epy * epy);
        end
        else
        begin
            r.region = psp_pkg::REGION_INTERIOR;
            if (vv == 0)
            begin
                r.degenerate = 1'b1;
                r.near_x     = item.start_x;
                r.near_y     = item.start_y;
                span_len     = floor_sqrt(spx * spx + spy * spy);
            end
            else
            begin
                cr       = vx * spy - vy * spx;
                span_len = floor_sqrt((cr * cr) / vv);
                r.near_x = psp_pkg::coord_t'(sx + (vx * d1) / vv);
                r.near_y = psp_pkg::coord_t'(sy + (vy * d1) / vv);
            end
        end
        r.saturated = (span_len > wide_t'(64'hFFFF_FFFF));
        r.distance  = r.saturated ? '1 : span_len[psp_pkg::COORD_WIDTH-1:0];
        return r;
    endfunction

    function automatic psp_pkg::coord_t small_coord(int span);
        return psp_pkg::coord_t'($urandom_range(2 * span) - span);
    endfunction

    function automatic psp_pkg::in_t random_segment_query();
        psp_pkg::in_t item;
        int  kind;
        kind = $urandom_range(9);
        if (kind < 3)
            item = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else if (kind < 7)
        begin
            item.start_x = small_coord(1 << ($urandom_range(20)));
            item.start_y = small_coord(1 << ($urandom_range(20)));
            item.end_x   = small_coord(1 << ($urandom_range(20)));
            item.end_y   = small_coord(1 << ($urandom_range(20)));
            item.query_x = small_coord(1 << ($urandom_range(20)));
            item.query_y = small_coord(1 << ($urandom_range(20)));
        end
        else if (kind < 8)
        begin
            item = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            item.end_x = item.start_x;
            item.end_y = item.start_y;
        end
        else
        begin
            item.start_x = small_coord(4096);
            item.start_y = small_coord(4096);
            item.end_x   = item.start_x + 2 * small_coord(2048);
            item.end_y   = item.start_y + 2 * small_coord(2048);
            item.query_x = item.start_x + (item.end_x - item.start_x) / 2 + small_coord(8);
            item.query_y = item.start_y + (item.end_y - item.start_y) / 2 + small_coord(8);
        end
        return item;
    endfunction

    initial
    begin
        psp_pkg::coord_t mn, mx;
        mn = psp_pkg::coord_t'(32'h8000_0000);
        mx = psp_pkg::coord_t'(32'h7FFF_FFFF);
        pending_items.push_back({mn, mn, mx, mx, mn, mn});
        pending_items.push_back({mn, mn, mx, mx, mx, mx});
        pending_items.push_back({mx, mx, mn, mn, mn, mn});
        pending_items.push_back({mn, mn, mn, mn, mx, mx});
        pending_items.push_back({mx, mn, mx, mn, mn, mx});
        pending_items.push_back({mn, mx, mx, mn, mn, mn});
        pending_items.push_back({mn, mx, mx, mn, mx, mx});
        pending_items.push_back({mn, mn, mx, mn, 32'sd0, mx});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, -32'sd65536});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd0, -32'sd5, 32'sd3});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd0, 32'sd15, -32'sd3});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd0, 32'sd5, 32'sd3});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd0, 32'sd10, 32'sd7});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd10, 32'sd0, 32'sd0, -32'sd7});
        pending_items.push_back({32'sd0, 32'sd0, 32'sd3, 32'sd7, 32'sd1, 32'sd1});
        pending_items.push_back({-32'sd1, -32'sd1, 32'sd2, -32'sd7, -32'sd1, 32'sd2});
        pending_items.push_back({32'sd7, -32'sd3, -32'sd9, 32'sd5, 32'sd1, 32'sd4});
        pending_items.push_back({mx, mx, mx, mx, mn, mn});
        pending_items.push_back({mn, 32'sd0, mx, 32'sd1, 32'sd0, mx});
        for (int i = 0; i < NUM_RANDOM; i++)
            pending_items.push_back(random_segment_query());
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            request    <= '0;
            sent_count <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(project_point(request));
                sent_count <= sent_count + 1;
            end
            if (!(start && busy))
            begin
                if (pending_items.size() > 0 &&
                    (sent_count > 400 && sent_count < 700 || $urandom_range(99) >= 14))
                begin
                    request <= pending_items.pop_front();
                    start   <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        psp_pkg::out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                checked_count++;
                case (want.region)
                    psp_pkg::REGION_BEFORE:   n_before++;
                    psp_pkg::REGION_PAST:     n_past++;
                    default:                  n_interior++;
                endcase
                n_degen += want.degenerate;
                n_sat   += want.saturated;
                if (result.near_x !== want.near_x)
                begin
                    $error("near_x: expected %0d, got %0d", want.near_x, result.near_x);
                    error_count++;
                end
                if (result.near_y !== want.near_y)
                begin
                    $error("near_y: expected %0d, got %0d", want.near_y, result.near_y);
                    error_count++;
                end
                if (result.distance !== want.distance)
                begin
                    $error("distance: expected %0d, got %0d", want.distance, result.distance);
                    error_count++;
                end
                if (result.region !== want.region)
                begin
                    $error("region: expected %0d, got %0d", want.region, result.region);
                    error_count++;
                end
                if (result.degenerate !== want.degenerate)
                begin
                    $error("degenerate: expected %0b, got %0b",
                           want.degenerate, result.degenerate);
                    error_count++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, result.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        checked_count = 0;
        error_count   = 0;
        quiet_cycles  = 0;
        n_before      = 0;
        n_past        = 0;
        n_interior    = 0;
        n_degen       = 0;
        n_sat         = 0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_items.size() > 0 || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (psp_pkg::LATENCY + 10) @(posedge clk);
        $display("checked %0d results: %0d before start, %0d past end, %0d interior",
                 checked_count, n_before, n_past, n_interior);
        $display("degenerate segments %0d, saturated distances %0d", n_degen, n_sat);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/psp_pkg.sv
hdl/point_segment_projection_unit.sv
bench/point_segment_projection_unit_tb.sv
